FILE: rtl/core/summed_area_window_sum_assert.svh
// assertion helpers for the summed-area window sum block
// each macro expects clock and reset in scope
`ifndef SUMMED_AREA_WINDOW_SUM_ASSERT_SVH
`define SUMMED_AREA_WINDOW_SUM_ASSERT_SVH

// same-cycle implication
`define SAWS_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SAWS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/saws_pkg.sv
package saws_pkg;

   localparam int MAX_COLS   = 64;
   localparam int MAX_ROWS   = 64;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;

   localparam int X_W       = $clog2(MAX_COLS);
   localparam int Y_W       = $clog2(MAX_ROWS);
   localparam int ADDR_W    = $clog2(CELL_COUNT);
   localparam int COLS_CW   = $clog2(MAX_COLS + 1);
   localparam int ROWS_CW   = $clog2(MAX_ROWS + 1);
   localparam int POS_W     = $clog2(CELL_COUNT + 1);
   localparam int DIV_CNT_W = $clog2(POS_W);
   localparam int CRD_W     = (X_W > Y_W) ? X_W : Y_W;
   localparam int BND_W     = ((CRD_W > 7) ? CRD_W : 7) + 2;

   localparam int CELL_W = 32;
   localparam int SUM_W  = 48;
   localparam int ACC_W  = SUM_W + 2;
   localparam int CFG_W  = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b1;

   // item actions
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_RECT = 2'd1;
   localparam logic [1:0] ACT_SPAN = 2'd2;

   // result kinds
   localparam logic KIND_RECT = 1'b0;
   localparam logic KIND_SPAN = 1'b1;

   typedef struct packed {
      logic [COLS_CW-1:0] cols;
      logic [ROWS_CW-1:0] rows;
      logic               rows_wr;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [CELL_W-1:0] cell_value;
      logic [5:0]        center_x;
      logic [5:0]        center_y;
      logic [6:0]        radius;
      logic signed [6:0] row_offset;
      logic              first;
   } cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] rd_addr0;
      logic [ADDR_W-1:0] rd_addr1;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [SUM_W-1:0]  wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [SUM_W-1:0] rd_data0;
      logic [SUM_W-1:0] rd_data1;
   } mem_rsp_type;

   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] sum;
      logic             kind;
   } res_type;

   // entry (x, y) sits at x*MAX_ROWS + y
   function automatic logic [ADDR_W-1:0] cell_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      logic [ADDR_W-1:0] xa;
      xa = ADDR_W'(x);
      return ADDR_W'(xa * ADDR_W'(MAX_ROWS)) + ADDR_W'(y);
   endfunction

   function automatic logic [SUM_W-1:0] sat_sum(logic [ACC_W-1:0] v);
      return (v > ACC_W'(SUM_MAX)) ? SUM_MAX : v[SUM_W-1:0];
   endfunction

   // plus - minus, floored at zero and saturated
   function automatic logic [SUM_W-1:0] clamp_diff(logic [ACC_W-1:0] plus,
                                                   logic [ACC_W-1:0] minus);
      logic [ACC_W-1:0] d;
      logic [SUM_W-1:0] r;
      d = plus - minus;
      if (plus > minus) begin
         r = sat_sum(d);
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/saws_ram.sv
module saws_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd0_ff;
   logic [WIDTH-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_ff <= mem[rd_addr0];
      rd1_ff <= mem[rd_addr1];
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

FILE: rtl/core/saws_core.sv
`include "summed_area_window_sum_assert.svh"

module saws_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  saws_pkg::cmd_type     cmd,
   output logic                  cmd_ready,
   input  saws_pkg::cfg_type     cfg,
   input  logic                  out_free,
   output saws_pkg::mem_req_type area_req,
   input  saws_pkg::mem_rsp_type area_rsp,
   output saws_pkg::mem_req_type row_req,
   input  saws_pkg::mem_rsp_type row_rsp,
   output saws_pkg::res_type     res
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DIV     = 4'd1;
   localparam logic [3:0] S_LD_RD   = 4'd2;
   localparam logic [3:0] S_LD_RD2  = 4'd3;
   localparam logic [3:0] S_LD_SUM  = 4'd4;
   localparam logic [3:0] S_LD_WR   = 4'd5;
   localparam logic [3:0] S_RQ_RD   = 4'd6;
   localparam logic [3:0] S_RQ_RD2  = 4'd7;
   localparam logic [3:0] S_RQ_SUM  = 4'd8;
   localparam logic [3:0] S_RQ_DIF  = 4'd9;
   localparam logic [3:0] S_SP_RD   = 4'd10;
   localparam logic [3:0] S_SP_DIF  = 4'd11;
   localparam logic [3:0] S_SP_TOT  = 4'd12;
   localparam logic [3:0] S_DONE    = 4'd13;

   localparam int X_W   = saws_pkg::X_W;
   localparam int Y_W   = saws_pkg::Y_W;
   localparam int POS_W = saws_pkg::POS_W;
   localparam int BND_W = saws_pkg::BND_W;
   localparam int ACC_W = saws_pkg::ACC_W;
   localparam int SUM_W = saws_pkg::SUM_W;
   localparam int RCW   = saws_pkg::ROWS_CW;
   localparam int DCW   = saws_pkg::DIV_CNT_W;

   // control state
   logic [3:0]       state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [X_W-1:0]   x_ff, x_in;
   logic [Y_W-1:0]   y_ff, y_in;
   logic             dirty_ff, dirty_in;
   logic [SUM_W-1:0] total_ff, total_in;

   // per-item payload
   logic [saws_pkg::CELL_W-1:0] value_ff, value_in;
   logic             first_ff, first_in;
   logic [X_W-1:0]   xl_ff, xl_in, xu_ff, xu_in;
   logic [Y_W-1:0]   yl_ff, yl_in, yu_ff, yu_in, row_ff, row_in;
   logic             xl_nz_ff, xl_nz_in, yl_nz_ff, yl_nz_in;
   logic             empty_ff, empty_in;
   logic [ACC_W-1:0] plus_ff, plus_in, minus_ff, minus_in;
   logic [SUM_W-1:0] hold_ff, hold_in, rowsum_ff, rowsum_in;
   logic [SUM_W-1:0] res_sum_ff, res_sum_in;
   logic             res_kind_ff, res_kind_in;

   // position divider
   logic [POS_W-1:0] dvd_ff, dvd_in, quo_ff, quo_in, quo_step;
   logic [RCW-1:0]   rem_ff, rem_in, rem_step;
   logic [RCW:0]     rem_ext, rows_ext;
   logic [DCW-1:0]   cnt_ff, cnt_in;
   logic             q_bit;

   // window bounds of the incoming item
   logic signed [BND_W-1:0] lo_x, hi_x, lo_y, hi_y, row_s;
   logic signed [BND_W-1:0] xl_c, xu_c, yl_c, yu_c, cols_m1, rows_m1;
   logic             empty_x, empty_y, row_ok;
   logic [POS_W-1:0] limit, pos_start;
   logic             grid_full;
   logic [Y_W:0]     y_inc;

   logic             x_nz, y_nz;
   logic [X_W-1:0]   x_m1, xl_m1;
   logic [Y_W-1:0]   y_m1, yl_m1;
   logic [SUM_W-1:0] tot;

   assign cmd_ready = (state_ff == S_IDLE);

   assign x_nz  = (x_ff != '0);
   assign y_nz  = (y_ff != '0);
   assign x_m1  = x_ff - X_W'(1);
   assign y_m1  = y_ff - Y_W'(1);
   assign xl_m1 = xl_ff - X_W'(1);
   assign yl_m1 = yl_ff - Y_W'(1);

   always_comb begin
      cols_m1 = BND_W'(cfg.cols) - BND_W'(1);
      rows_m1 = BND_W'(cfg.rows) - BND_W'(1);
      lo_x = BND_W'(cmd.center_x) - BND_W'(cmd.radius);
      hi_x = BND_W'(cmd.center_x) + BND_W'(cmd.radius);
      lo_y = BND_W'(cmd.center_y) - BND_W'(cmd.radius);
      hi_y = BND_W'(cmd.center_y) + BND_W'(cmd.radius);
      row_s = BND_W'(cmd.center_y) + {{(BND_W-7){cmd.row_offset[6]}}, cmd.row_offset};
      xl_c = lo_x[BND_W-1] ? '0 : lo_x;
      yl_c = lo_y[BND_W-1] ? '0 : lo_y;
      xu_c = (hi_x > cols_m1) ? cols_m1 : hi_x;
      yu_c = (hi_y > rows_m1) ? rows_m1 : hi_y;
      empty_x = (xl_c > xu_c);
      empty_y = (yl_c > yu_c);
      row_ok  = !row_s[BND_W-1] && (row_s <= rows_m1);
      limit = POS_W'(cfg.cols) * POS_W'(cfg.rows);
      pos_start = cmd.first ? '0 : pos_ff;
      grid_full = (pos_start >= limit);
      y_inc = {1'b0, y_ff} + (Y_W+1)'(1);
   end

   // one restoring step of position / rows
   always_comb begin
      rows_ext = {1'b0, cfg.rows};
      rem_ext  = {rem_ff, dvd_ff[POS_W-1]};
      q_bit    = (rem_ext >= rows_ext);
      if (q_bit) begin
         rem_step = RCW'(rem_ext - rows_ext);
      end else begin
         rem_step = rem_ext[RCW-1:0];
      end
      quo_step = {quo_ff[POS_W-2:0], q_bit};
   end

   assign tot = saws_pkg::sat_sum(ACC_W'(first_ff ? '0 : total_ff) + plus_ff);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      dirty_in = dirty_ff;
      total_in = total_ff;
      value_in = value_ff;
      first_in = first_ff;
      xl_in    = xl_ff;
      xu_in    = xu_ff;
      yl_in    = yl_ff;
      yu_in    = yu_ff;
      row_in   = row_ff;
      xl_nz_in = xl_nz_ff;
      yl_nz_in = yl_nz_ff;
      empty_in = empty_ff;
      plus_in  = plus_ff;
      minus_in = minus_ff;
      hold_in  = hold_ff;
      rowsum_in = rowsum_ff;
      res_sum_in  = res_sum_ff;
      res_kind_in = res_kind_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      res.valid = 1'b0;
      res.sum   = res_sum_ff;
      res.kind  = res_kind_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               value_in = cmd.cell_value;
               first_in = cmd.first;
               xl_in    = xl_c[X_W-1:0];
               xu_in    = xu_c[X_W-1:0];
               yl_in    = yl_c[Y_W-1:0];
               yu_in    = yu_c[Y_W-1:0];
               row_in   = row_s[Y_W-1:0];
               xl_nz_in = (xl_c != '0);
               yl_nz_in = (yl_c != '0);
               case (cmd.action)
                  saws_pkg::ACT_LOAD: begin
                     if (cmd.first) begin
                        pos_in   = '0;
                        x_in     = '0;
                        y_in     = '0;
                        dirty_in = 1'b0;
                     end
                     if (!grid_full) begin
                        if (!cmd.first && dirty_ff) begin
                           dvd_in   = pos_ff;
                           quo_in   = '0;
                           rem_in   = '0;
                           cnt_in   = DCW'(POS_W - 1);
                           state_in = S_DIV;
                        end else begin
                           state_in = S_LD_RD;
                        end
                     end
                  end
                  saws_pkg::ACT_RECT: begin
                     empty_in = empty_x || empty_y;
                     state_in = S_RQ_RD;
                  end
                  saws_pkg::ACT_SPAN: begin
                     empty_in = empty_x || !row_ok;
                     state_in = S_SP_RD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_DIV: begin
            dvd_in = dvd_ff << 1;
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - DCW'(1);
            if (cnt_ff == '0) begin
               x_in     = quo_step[X_W-1:0];
               y_in     = rem_step[Y_W-1:0];
               dirty_in = 1'b0;
               state_in = S_LD_RD;
            end
         end
         S_LD_RD: begin
            state_in = S_LD_RD2;
         end
         S_LD_RD2: begin
            plus_in   = ACC_W'(value_ff) + (x_nz ? ACC_W'(area_rsp.rd_data0) : '0);
            hold_in   = y_nz ? area_rsp.rd_data1 : '0;
            rowsum_in = saws_pkg::sat_sum(ACC_W'(value_ff)
                                          + (x_nz ? ACC_W'(row_rsp.rd_data0) : '0));
            state_in  = S_LD_SUM;
         end
         S_LD_SUM: begin
            plus_in  = plus_ff + ACC_W'(hold_ff);
            minus_in = (x_nz && y_nz) ? ACC_W'(area_rsp.rd_data0) : '0;
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            pos_in = pos_ff + POS_W'(1);
            if (32'(y_inc) == 32'(cfg.rows)) begin
               y_in = '0;
               x_in = x_ff + X_W'(1);
            end else begin
               y_in = y_inc[Y_W-1:0];
            end
            state_in = S_IDLE;
         end
         S_RQ_RD: begin
            state_in = S_RQ_RD2;
         end
         S_RQ_RD2: begin
            plus_in  = ACC_W'(area_rsp.rd_data0);
            minus_in = xl_nz_ff ? ACC_W'(area_rsp.rd_data1) : '0;
            state_in = S_RQ_SUM;
         end
         S_RQ_SUM: begin
            plus_in  = plus_ff + ((xl_nz_ff && yl_nz_ff) ? ACC_W'(area_rsp.rd_data1) : '0);
            minus_in = minus_ff + (yl_nz_ff ? ACC_W'(area_rsp.rd_data0) : '0);
            state_in = S_RQ_DIF;
         end
         S_RQ_DIF: begin
            res_sum_in  = empty_ff ? '0 : saws_pkg::clamp_diff(plus_ff, minus_ff);
            res_kind_in = saws_pkg::KIND_RECT;
            state_in    = S_DONE;
         end
         S_SP_RD: begin
            state_in = S_SP_DIF;
         end
         S_SP_DIF: begin
            if (empty_ff) begin
               plus_in = '0;
            end else if (xl_nz_ff) begin
               plus_in = ACC_W'(saws_pkg::clamp_diff(ACC_W'(row_rsp.rd_data0),
                                                    ACC_W'(row_rsp.rd_data1)));
            end else begin
               plus_in = ACC_W'(row_rsp.rd_data0);
            end
            state_in = S_SP_TOT;
         end
         S_SP_TOT: begin
            total_in    = tot;
            res_sum_in  = tot;
            res_kind_in = saws_pkg::KIND_SPAN;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               res.valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a new row count makes x and y stale
      if (cfg.rows_wr) begin
         dirty_in = 1'b1;
      end
   end

   // store addressing
   always_comb begin
      area_req.rd_addr0 = saws_pkg::cell_addr(x_m1, y_ff);
      area_req.rd_addr1 = saws_pkg::cell_addr(x_ff, y_m1);
      area_req.wr_en    = 1'b0;
      area_req.wr_addr  = saws_pkg::cell_addr(x_ff, y_ff);
      area_req.wr_data  = saws_pkg::clamp_diff(plus_ff, minus_ff);
      row_req.rd_addr0  = saws_pkg::cell_addr(x_m1, y_ff);
      row_req.rd_addr1  = saws_pkg::cell_addr(xl_m1, row_ff);
      row_req.wr_en     = 1'b0;
      row_req.wr_addr   = saws_pkg::cell_addr(x_ff, y_ff);
      row_req.wr_data   = rowsum_ff;
      case (state_ff)
         S_LD_RD2: begin
            area_req.rd_addr0 = saws_pkg::cell_addr(x_m1, y_m1);
         end
         S_LD_WR: begin
            area_req.wr_en = 1'b1;
            row_req.wr_en  = 1'b1;
         end
         S_RQ_RD: begin
            area_req.rd_addr0 = saws_pkg::cell_addr(xu_ff, yu_ff);
            area_req.rd_addr1 = saws_pkg::cell_addr(xl_m1, yu_ff);
         end
         S_RQ_RD2: begin
            area_req.rd_addr0 = saws_pkg::cell_addr(xu_ff, yl_m1);
            area_req.rd_addr1 = saws_pkg::cell_addr(xl_m1, yl_m1);
         end
         S_SP_RD: begin
            row_req.rd_addr0 = saws_pkg::cell_addr(xu_ff, row_ff);
         end
         default: begin
            area_req.wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= '0;
         x_ff     <= '0;
         y_ff     <= '0;
         dirty_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         dirty_ff <= dirty_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      first_ff    <= first_in;
      xl_ff       <= xl_in;
      xu_ff       <= xu_in;
      yl_ff       <= yl_in;
      yu_ff       <= yu_in;
      row_ff      <= row_in;
      xl_nz_ff    <= xl_nz_in;
      yl_nz_ff    <= yl_nz_in;
      empty_ff    <= empty_in;
      plus_ff     <= plus_in;
      minus_ff    <= minus_in;
      hold_ff     <= hold_in;
      rowsum_ff   <= rowsum_in;
      res_sum_ff  <= res_sum_in;
      res_kind_ff <= res_kind_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
   end

   `SAWS_ASSERT_IMPLY(a_store_write_step, area_req.wr_en || row_req.wr_en, state_ff == S_LD_WR, "store written outside the write step")
   `SAWS_ASSERT_IMPLY(a_result_has_room, res.valid, out_free, "result issued while output register full")
   `SAWS_ASSERT_IMPLY(a_accept_when_idle, cmd_valid, state_ff == S_IDLE, "item accepted while busy")
   `SAWS_ASSERT_NEXT(a_load_advances, state_ff == S_LD_WR, pos_ff == POS_W'($past(pos_ff) + 1'b1), "load position did not advance by one")

endmodule

FILE: rtl/core/summed_area_window_sum.sv
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   tdata: cell value and query operands
//                                       tuser: action, first
// rsp      out  rsp_tvalid/rsp_tready   tdata: window_sum, tuser: query_kind
// csr      in   csr_wen                 csr_index, csr_wdata
//
// a load: read, read, sum, write; a rectangle query: read, read, sum, difference;
// a row span query: read, difference, total; the next load after a rows_in_use
// write without first set runs the position divider (one quotient bit a cycle);
// the steps follow the prefix-store reads over two read ports per store (four
// reads for a rectangle) and the 50-bit add/compare chain, one step per cycle
// reset is synchronous; it clears the sequencer, load position, row total and the
// output register, the prefix stores are not cleared and read as garbage until loaded
// a finished result waits in the output register; the next item is accepted
// meanwhile, and the sequencer holds in its last step only while that register
// is full and not being drained

module summed_area_window_sum (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] cell_value, [37:32] center_x, [43:38] center_y, [50:44] radius,
   // [57:51] row_offset, [63:58] zero
   input  logic [63:0] req_tdata,
   // [1:0] action, [2] first
   input  logic [2:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [47:0] window_sum
   output logic [47:0] rsp_tdata,
   // [0] query_kind
   output logic [0:0]  rsp_tuser,
   // register write port
   input  logic        csr_wen,
   input  logic [saws_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [saws_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int CFG_W = saws_pkg::CFG_W;

   logic [CFG_W-1:0] cols_raw_ff, cols_raw_in;
   logic [CFG_W-1:0] rows_raw_ff, rows_raw_in;

   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [47:0] rsp_tdata_ff, rsp_tdata_in;
   logic        rsp_kind_ff, rsp_kind_in;

   saws_pkg::cmd_type     cmd;
   saws_pkg::cfg_type     cfg;
   saws_pkg::mem_req_type area_req, row_req;
   saws_pkg::mem_rsp_type area_rsp, row_rsp;
   saws_pkg::res_type     res;

   logic cmd_ready, cmd_valid, out_free;
   logic [saws_pkg::SUM_W-1:0] area_rd0, area_rd1, row_rd0, row_rd1;

   // unpack the request item
   always_comb begin
      cmd.action     = req_tuser[1:0];
      cmd.first      = req_tuser[2];
      cmd.cell_value = req_tdata[31:0];
      cmd.center_x   = req_tdata[37:32];
      cmd.center_y   = req_tdata[43:38];
      cmd.radius     = req_tdata[50:44];
      cmd.row_offset = req_tdata[57:51];
   end

   assign req_tready = cmd_ready;
   assign cmd_valid  = req_tvalid && cmd_ready;

   // register writes
   always_comb begin
      cols_raw_in = cols_raw_ff;
      rows_raw_in = rows_raw_ff;
      if (csr_wen) begin
         case (csr_index)
            saws_pkg::CSR_COLS: cols_raw_in = csr_wdata;
            saws_pkg::CSR_ROWS: rows_raw_in = csr_wdata;
            default: cols_raw_in = cols_raw_ff;
         endcase
      end
   end

   // grid extents clamped to 1..max
   always_comb begin
      if (cols_raw_ff == '0) begin
         cfg.cols = saws_pkg::COLS_CW'(1);
      end else if (32'(cols_raw_ff) > saws_pkg::MAX_COLS) begin
         cfg.cols = saws_pkg::COLS_CW'(saws_pkg::MAX_COLS);
      end else begin
         cfg.cols = saws_pkg::COLS_CW'(cols_raw_ff);
      end
      if (rows_raw_ff == '0) begin
         cfg.rows = saws_pkg::ROWS_CW'(1);
      end else if (32'(rows_raw_ff) > saws_pkg::MAX_ROWS) begin
         cfg.rows = saws_pkg::ROWS_CW'(saws_pkg::MAX_ROWS);
      end else begin
         cfg.rows = saws_pkg::ROWS_CW'(rows_raw_ff);
      end
      cfg.rows_wr = csr_wen && (csr_index == saws_pkg::CSR_ROWS);
   end

   // output register, free when empty or draining this cycle
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_kind_in   = rsp_kind_ff;
      if (res.valid) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = res.sum;
         rsp_kind_in   = res.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_raw_ff   <= CFG_W'(saws_pkg::MAX_COLS);
         rows_raw_ff   <= CFG_W'(saws_pkg::MAX_ROWS);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cols_raw_ff   <= cols_raw_in;
         rows_raw_ff   <= rows_raw_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // 2d summed-area store
   saws_ram #(
      .DEPTH (saws_pkg::CELL_COUNT),
      .WIDTH (saws_pkg::SUM_W)
   ) u_area_ram (
      .clock    (clock),
      .wr_en    (area_req.wr_en),
      .wr_addr  (area_req.wr_addr),
      .wr_data  (area_req.wr_data),
      .rd_addr0 (area_req.rd_addr0),
      .rd_addr1 (area_req.rd_addr1),
      .rd_data0 (area_rd0),
      .rd_data1 (area_rd1)
   );

   // prefix store along x
   saws_ram #(
      .DEPTH (saws_pkg::CELL_COUNT),
      .WIDTH (saws_pkg::SUM_W)
   ) u_row_ram (
      .clock    (clock),
      .wr_en    (row_req.wr_en),
      .wr_addr  (row_req.wr_addr),
      .wr_data  (row_req.wr_data),
      .rd_addr0 (row_req.rd_addr0),
      .rd_addr1 (row_req.rd_addr1),
      .rd_data0 (row_rd0),
      .rd_data1 (row_rd1)
   );

   always_comb begin
      area_rsp.rd_data0 = area_rd0;
      area_rsp.rd_data1 = area_rd1;
      row_rsp.rd_data0  = row_rd0;
      row_rsp.rd_data1  = row_rd1;
   end

   // sequencer and datapath
   saws_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .cfg       (cfg),
      .out_free  (out_free),
      .area_req  (area_req),
      .area_rsp  (area_rsp),
      .row_req   (row_req),
      .row_rsp   (row_rsp),
      .res       (res)
   );

endmodule
